[rtl/msm_pkg.sv]
package msm_pkg;

  // signature storage is fixed by the register widths
  localparam int SIG_BYTES = 16;
  localparam int LEN_W     = 5;

  // configuration register indexes
  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_PATTERN_LOW    = 2'd0;
  localparam reg_index_t REG_PATTERN_HIGH   = 2'd1;
  localparam reg_index_t REG_CARE_MASK      = 2'd2;
  localparam reg_index_t REG_PATTERN_LENGTH = 2'd3;

  // byte handed from one cell to the next
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } cell_word_t;

  // what a cell compares against for the current window
  typedef struct packed {
    logic       active;
    logic       care;
    logic [7:0] sig_byte;
  } cell_check_t;

endpackage

[rtl/msm_cell.sv]
module msm_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                flush,
  input  msm_pkg::cell_word_t prev,
  input  msm_pkg::cell_check_t chk,
  output msm_pkg::cell_word_t word,
  output logic                ok
);
  import msm_pkg::*;

  logic       valid;
  logic [7:0] data;
  logic       valid_eff;

  // history byte of this age, cleared logically at a region start
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data <= prev.data;
    end
  end

  assign valid_eff  = valid & ~flush;
  assign word.valid = valid_eff;
  assign word.data  = data;

  // inactive positions pass; active ones need history and, where care is set, a byte match
  assign ok = !chk.active || (valid_eff && (!chk.care || data == chk.sig_byte));

endmodule

[rtl/masked_signature_scan.sv]
// Masked signature scanner. Takes one memory byte per cycle, unless stalled, with
// its address and reports the start address of the first match of the signature
// (up to 16 bytes, wildcard positions where care_mask is clear) within a scan, or
// a no-match word on the scan's last byte. A row of history cells shifts the
// bytes of the current region by one place per accepted byte, and every cell
// compares its byte with the signature byte for its age in the same cycle, so a
// byte is taken every unstalled cycle and its result word reaches the output
// register in the next cycle. item_stall is raised only while a result word waits
// and result_stall holds it. No clearing pass is needed after reset.
module masked_signature_scan #(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  msm_pkg::reg_index_t cfg_index,
  input  logic [63:0]        cfg_data,
  // input words
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [7:0]         data_byte,
  input  logic [63:0]        byte_address,
  input  logic               region_first,
  input  logic               scan_first,
  input  logic               scan_last,
  // result words
  output logic               result_valid,
  input  logic               result_stall,
  output logic               match_found,
  output logic [63:0]        match_address
);
  import msm_pkg::*;

  localparam int SIG_LIMIT = (MAX_PATTERN_BYTES < SIG_BYTES) ? MAX_PATTERN_BYTES : SIG_BYTES;
  localparam int HAND_TOP  = (SIG_LIMIT > 1) ? SIG_LIMIT - 2 : 0;
  localparam logic [LEN_W-1:0] LIMIT_LEN = LEN_W'(SIG_LIMIT);

  logic [63:0]      pattern_low;
  logic [63:0]      pattern_high;
  logic [15:0]      care_mask;
  logic [LEN_W-1:0] pattern_length;
  logic             found;
  logic             found_next;

  logic [SIG_BYTES-1:0][7:0] sig;
  logic [LEN_W-1:0]          len_eff;
  logic                      advance;
  logic                      found_eff;
  logic                      hit;
  logic                      end_miss;

  cell_check_t chk  [SIG_LIMIT];
  cell_word_t  hand [HAND_TOP+1];
  logic [SIG_LIMIT-1:0] ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= 16'hFFFF;
      pattern_length <= LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_CARE_MASK:      care_mask      <= cfg_data[15:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign sig = {pattern_high, pattern_low};

  // length clamped to 1 .. supported maximum
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LIMIT_LEN) begin
      len_eff = LIMIT_LEN;
    end else begin
      len_eff = pattern_length;
    end
  end

  // handshake: new word whenever the result register is free or draining
  assign item_stall = result_valid && result_stall;
  assign advance    = item_valid && !item_stall;

  // signature byte and care bit for each age in the window
  for (genvar k = 0; k < SIG_LIMIT; k++) begin : g_check
    logic [3:0] j;
    assign j                = 4'(len_eff - LEN_W'(1) - LEN_W'(k));
    assign chk[k].active    = LEN_W'(k) < len_eff;
    assign chk[k].care      = care_mask[j];
    assign chk[k].sig_byte  = sig[j];
  end

  // newest byte is compared directly, it is always in the window
  assign ok[0]   = !chk[0].care || data_byte == chk[0].sig_byte;
  assign hand[0] = '{valid: 1'b1, data: data_byte};

  // row of history cells, cell k holds the byte of age k
  for (genvar k = 1; k < SIG_LIMIT; k++) begin : g_cell
    if (k <= HAND_TOP) begin : g_mid
      msm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .advance (advance),
        .flush   (region_first),
        .prev    (hand[k-1]),
        .chk     (chk[k]),
        .word    (hand[k]),
        .ok      (ok[k])
      );
    end else begin : g_end
      msm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .advance (advance),
        .flush   (region_first),
        .prev    (hand[k-1]),
        .chk     (chk[k]),
        .word    (),
        .ok      (ok[k])
      );
    end
  end

  // match decision
  assign found_eff  = found && !scan_first;
  assign hit        = !found_eff && (&ok);
  assign end_miss   = !hit && scan_last && !found_eff;
  assign found_next = hit || found_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (advance) begin
      found <= found_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && (hit || end_miss)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (hit || end_miss)) begin
      match_found   <= hit;
      match_address <= hit ? byte_address - 64'(len_eff - LEN_W'(1)) : '0;
    end
  end

`ifndef NO_ASSERTIONS
  // a no-match word carries a zero address
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !match_found |-> match_address == '0)
    else $error("no-match word with nonzero address");

  // the found flag only comes up together with a match word
  assert property (@(posedge clk) disable iff (rst)
    $rose(found) |-> result_valid && match_found)
    else $error("found flag set without a match word");

  // a taken word leaves unless a new word was accepted
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !advance |=> !result_valid)
    else $error("result word repeated");
`endif

endmodule
